FILE: rtl/cc20_pkg.sv
`default_nettype none

package cc20_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned NUM_WORDS   = 16;
    localparam int unsigned NUM_LANES   = 4;
    localparam int unsigned NUM_ROUNDS  = 20;
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned POS_W       = $clog2(BLOCK_BYTES);
    localparam int unsigned ROUND_W     = $clog2(NUM_ROUNDS);
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam word_t SIGMA_0 = 32'h6170_7865;
    localparam word_t SIGMA_1 = 32'h3320_646e;
    localparam word_t SIGMA_2 = 32'h7962_2d32;
    localparam word_t SIGMA_3 = 32'h6b20_6574;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GEN,
        ST_FIN,
        ST_EMIT
    } state_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_0,
        REG_KEY_1,
        REG_KEY_2,
        REG_KEY_3,
        REG_NONCE_0,
        REG_NONCE_1,
        REG_START_COUNT
    } cfg_reg_t;

    // Word roles within a quarter round
    localparam logic [1:0] ROLE_A = 2'd0;
    localparam logic [1:0] ROLE_B = 2'd1;
    localparam logic [1:0] ROLE_C = 2'd2;
    localparam logic [1:0] ROLE_D = 2'd3;

    // Column rounds: role*4 + lane. Diagonal rounds shift the lane by the role.
    function automatic logic [3:0] qr_index(input logic [1:0] lane, input logic diag,
                                            input logic [1:0] role);
        logic [1:0] off;
        off = diag ? 2'(lane + role) : lane;
        return {role, off};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cc20_qr_lane.sv
`default_nettype none

// One quarter-round step: p + q, then rotl(r ^ sum) by the step's amount.
module cc20_qr_lane (
    input  wire cc20_pkg::word_t p_word,
    input  wire cc20_pkg::word_t q_word,
    input  wire cc20_pkg::word_t r_word,
    input  wire logic [1:0]      step,
    output cc20_pkg::word_t      sum_word,
    output cc20_pkg::word_t      mix_word
);

    cc20_pkg::word_t x_word;

    assign sum_word = p_word + q_word;
    assign x_word   = r_word ^ sum_word;

    always_comb begin
        case (step)
            2'd0:    mix_word = {x_word[15:0], x_word[31:16]};
            2'd1:    mix_word = {x_word[19:0], x_word[31:20]};
            2'd2:    mix_word = {x_word[23:0], x_word[31:24]};
            2'd3:    mix_word = {x_word[24:0], x_word[31:25]};
            default: mix_word = x_word;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/chacha20_stream_cipher.sv
`default_nettype none

// ChaCha20 (256-bit key, 96-bit nonce, 32-bit block counter, 20 rounds), one
// byte per word: m_out_byte is s_data_byte XORed with the next keystream byte.
// The first byte of a message loads the block counter from start_count; a byte
// with s_last_of_message set ends it. A byte inside a block is accepted, then
// loaded into the output register. A byte at a block boundary first loads the
// state, then runs the 20 rounds on four shared quarter-round step units (one
// add, xor and rotate per unit per cycle), then the final feed-forward add on
// the same units, and then loads the output. The output register lets the next
// byte be accepted while a result is still waiting.
module chacha20_stream_cipher (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [cc20_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cc20_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [7:0]                       s_data_byte,
    input  wire logic                             s_last_of_message,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [7:0]                            m_out_byte
);

    localparam int unsigned NW = cc20_pkg::NUM_WORDS;
    localparam int unsigned NL = cc20_pkg::NUM_LANES;
    localparam int unsigned PW = cc20_pkg::POS_W;
    localparam int unsigned RW = cc20_pkg::ROUND_W;

    // Configuration
    logic [63:0] key_reg [4];
    logic [63:0] nonce_0_reg;
    logic [31:0] nonce_1_reg;
    logic [31:0] start_count_reg;

    // Control
    cc20_pkg::state_t state_reg, state_next;
    logic [1:0]    step_reg, step_next;
    logic [RW-1:0] round_reg, round_next;
    logic [PW-1:0] byte_pos_reg, byte_pos_next;
    logic [PW-1:0] cur_pos_reg, cur_pos_next;
    logic [31:0]   block_count_reg, block_count_next;
    logic [31:0]   gen_count_reg, gen_count_next;
    logic          fresh_reg, fresh_next;
    logic          m_valid_reg, m_valid_next;

    // Payload
    cc20_pkg::word_t words_reg [NW];
    cc20_pkg::word_t words_next [NW];
    logic [7:0]      data_reg;
    logic [7:0]      m_out_byte_reg;

    logic            accept;
    logic            need_block;
    logic            emit_load;
    logic [PW-1:0]   eff_pos;
    logic [31:0]     eff_count;
    logic [31:0]     init_count;
    cc20_pkg::word_t init_w [NW];
    cc20_pkg::word_t ks_word;
    logic [7:0]      ks_byte;

    cc20_pkg::word_t lane_p [NL];
    cc20_pkg::word_t lane_q [NL];
    cc20_pkg::word_t lane_r [NL];
    cc20_pkg::word_t lane_sum [NL];
    cc20_pkg::word_t lane_mix [NL];
    logic [3:0]      p_idx [NL];
    logic [3:0]      q_idx [NL];
    logic [3:0]      r_idx [NL];
    logic [3:0]      fin_idx [NL];

    assign s_ready    = (state_reg == cc20_pkg::ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign eff_pos    = fresh_reg ? '0 : byte_pos_reg;
    assign eff_count  = fresh_reg ? start_count_reg : block_count_reg;
    assign need_block = (eff_pos == '0);
    assign emit_load  = (state_reg == cc20_pkg::ST_EMIT) && (!m_valid_reg || m_ready);
    assign init_count = (state_reg == cc20_pkg::ST_IDLE) ? eff_count : gen_count_reg;

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;

    // Configuration writes; index 7 is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            nonce_0_reg     <= '0;
            nonce_1_reg     <= '0;
            start_count_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cc20_pkg::REG_KEY_0:       key_reg[0]      <= cfg_wdata;
                cc20_pkg::REG_KEY_1:       key_reg[1]      <= cfg_wdata;
                cc20_pkg::REG_KEY_2:       key_reg[2]      <= cfg_wdata;
                cc20_pkg::REG_KEY_3:       key_reg[3]      <= cfg_wdata;
                cc20_pkg::REG_NONCE_0:     nonce_0_reg     <= cfg_wdata;
                cc20_pkg::REG_NONCE_1:     nonce_1_reg     <= cfg_wdata[31:0];
                cc20_pkg::REG_START_COUNT: start_count_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Initial block state
    always_comb begin
        init_w[0] = cc20_pkg::SIGMA_0;
        init_w[1] = cc20_pkg::SIGMA_1;
        init_w[2] = cc20_pkg::SIGMA_2;
        init_w[3] = cc20_pkg::SIGMA_3;
        for (int i = 0; i < 4; i++) begin
            init_w[4 + 2*i] = key_reg[i][31:0];
            init_w[5 + 2*i] = key_reg[i][63:32];
        end
        init_w[12] = init_count;
        init_w[13] = nonce_0_reg[31:0];
        init_w[14] = nonce_0_reg[63:32];
        init_w[15] = nonce_1_reg;
    end

    // Operand routing: even steps a += b, d ^= a; odd steps c += d, b ^= c; feed-forward adds init_w
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            p_idx[l]   = cc20_pkg::qr_index(2'(l), round_reg[0],
                             step_reg[0] ? cc20_pkg::ROLE_C : cc20_pkg::ROLE_A);
            q_idx[l]   = cc20_pkg::qr_index(2'(l), round_reg[0],
                             step_reg[0] ? cc20_pkg::ROLE_D : cc20_pkg::ROLE_B);
            r_idx[l]   = cc20_pkg::qr_index(2'(l), round_reg[0],
                             step_reg[0] ? cc20_pkg::ROLE_B : cc20_pkg::ROLE_D);
            fin_idx[l] = {step_reg, 2'(l)};
            if (state_reg == cc20_pkg::ST_FIN) begin
                lane_p[l] = words_reg[fin_idx[l]];
                lane_q[l] = init_w[fin_idx[l]];
            end else begin
                lane_p[l] = words_reg[p_idx[l]];
                lane_q[l] = words_reg[q_idx[l]];
            end
            lane_r[l] = words_reg[r_idx[l]];
        end
    end

    for (genvar g = 0; g < NL; g++) begin : g_lane
        cc20_qr_lane u_lane (
            .p_word   (lane_p[g]),
            .q_word   (lane_q[g]),
            .r_word   (lane_r[g]),
            .step     (step_reg),
            .sum_word (lane_sum[g]),
            .mix_word (lane_mix[g])
        );
    end

    always_comb begin
        for (int i = 0; i < NW; i++) words_next[i] = words_reg[i];
        case (state_reg)
            cc20_pkg::ST_IDLE: begin
                if (accept && need_block) begin
                    for (int i = 0; i < NW; i++) words_next[i] = init_w[i];
                end
            end
            cc20_pkg::ST_GEN: begin
                for (int l = 0; l < NL; l++) begin
                    words_next[p_idx[l]] = lane_sum[l];
                    words_next[r_idx[l]] = lane_mix[l];
                end
            end
            cc20_pkg::ST_FIN: begin
                for (int l = 0; l < NL; l++) words_next[fin_idx[l]] = lane_sum[l];
            end
            default: ;
        endcase
    end

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        step_next        = step_reg;
        round_next       = round_reg;
        byte_pos_next    = byte_pos_reg;
        cur_pos_next     = cur_pos_reg;
        block_count_next = block_count_reg;
        gen_count_next   = gen_count_reg;
        fresh_next       = fresh_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        case (state_reg)
            cc20_pkg::ST_IDLE: begin
                if (accept) begin
                    cur_pos_next  = eff_pos;
                    byte_pos_next = s_last_of_message ? '0 : PW'(eff_pos + 1'b1);
                    fresh_next    = s_last_of_message;
                    step_next     = '0;
                    round_next    = '0;
                    if (need_block) begin
                        gen_count_next   = eff_count;
                        block_count_next = eff_count + 32'd1;
                        state_next       = cc20_pkg::ST_GEN;
                    end else begin
                        state_next       = cc20_pkg::ST_EMIT;
                    end
                end
            end
            cc20_pkg::ST_GEN: begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    if (round_reg == RW'(cc20_pkg::NUM_ROUNDS - 1)) begin
                        round_next = '0;
                        state_next = cc20_pkg::ST_FIN;
                    end else begin
                        round_next = round_reg + 1'b1;
                    end
                end
            end
            cc20_pkg::ST_FIN: begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) state_next = cc20_pkg::ST_EMIT;
            end
            cc20_pkg::ST_EMIT: begin
                if (emit_load) begin
                    m_valid_next = 1'b1;
                    state_next   = cc20_pkg::ST_IDLE;
                end
            end
            default: state_next = cc20_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= cc20_pkg::ST_IDLE;
            step_reg        <= '0;
            round_reg       <= '0;
            byte_pos_reg    <= '0;
            cur_pos_reg     <= '0;
            block_count_reg <= '0;
            gen_count_reg   <= '0;
            fresh_reg       <= 1'b1;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            round_reg       <= round_next;
            byte_pos_reg    <= byte_pos_next;
            cur_pos_reg     <= cur_pos_next;
            block_count_reg <= block_count_next;
            gen_count_reg   <= gen_count_next;
            fresh_reg       <= fresh_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Keystream byte j is byte j%4 of word j/4
    assign ks_word = words_reg[cur_pos_reg[PW-1:2]];
    assign ks_byte = 8'(ks_word >> {cur_pos_reg[1:0], 3'b000});

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NW; i++) words_reg[i] <= words_next[i];
        if (accept) data_reg <= s_data_byte;
        if (emit_load) m_out_byte_reg <= data_reg ^ ks_byte;
    end

    a_fresh_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg |-> byte_pos_reg == '0)
        else $error("fresh message with nonzero byte position");

    a_fresh_makes_block: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && fresh_reg |=> state_reg == cc20_pkg::ST_GEN && gen_count_reg == $past(start_count_reg))
        else $error("message start did not generate a block from start_count");

    a_rounds_to_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == cc20_pkg::ST_GEN && step_reg == 2'd3
            && round_reg == RW'(cc20_pkg::NUM_ROUNDS - 1)
        |=> state_reg == cc20_pkg::ST_FIN && step_reg == 2'd0)
        else $error("round sequence did not end in feed-forward");

    a_emit_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_load |=> m_valid_reg && state_reg == cc20_pkg::ST_IDLE)
        else $error("result not presented after emit");

    a_count_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && need_block |=> block_count_reg == gen_count_reg + 32'd1)
        else $error("block counter not advanced after block generation");

endmodule

`default_nettype wire
